// File: rtl/core/tce_pkg.sv
package tce_pkg;

    // sample and statistic widths
    localparam int unsigned VAL_W   = 32;
    localparam int unsigned FRAC_W  = 16;
    localparam int unsigned CNT_W   = 32;
    localparam int unsigned SUM_W   = 64;
    localparam int unsigned SQ_W    = 63;
    localparam int unsigned PEAK_W  = 33;
    localparam int unsigned ERR_W   = VAL_W;            // |a-b| never exceeds 2^32-1
    localparam int unsigned PROD_W  = 2 * VAL_W;
    localparam int unsigned TERM_W  = PROD_W - FRAC_W;  // squared error in Q32.16

    // stream payload widths
    localparam int unsigned IN_TDATA_W  = 2 * VAL_W;
    localparam int unsigned OUT_BITS    = 1 + 5 * CNT_W + 2 * SUM_W + SQ_W + PEAK_W;
    localparam int unsigned OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_MODE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TOL     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MISSING = 2'd2;

    // compare modes
    localparam logic [1:0] CMP_EXACT = 2'd0;
    localparam logic [1:0] CMP_ABS   = 2'd1;
    localparam logic [1:0] CMP_REL   = 2'd2;

    // 1.0 in Q16.16
    localparam logic [VAL_W-1:0] Q_ONE = 32'h0001_0000;

    // one compared point handed to the statistics stage
    typedef struct packed {
        logic                    mismatch;
        logic                    miss_a;
        logic                    miss_b;
        logic                    start;
        logic signed [VAL_W-1:0] value_a;
        logic signed [VAL_W-1:0] value_b;
        logic [ERR_W-1:0]        abs_err;
        logic [TERM_W-1:0]       sq_term;
    } t_cmp_item;

endpackage

// File: rtl/core/tce_compare.sv
module tce_compare (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic signed [tce_pkg::VAL_W-1:0] i_value_a,
    input  logic signed [tce_pkg::VAL_W-1:0] i_value_b,
    input  logic                          i_start,
    input  logic [1:0]                    i_mode,
    input  logic [tce_pkg::VAL_W-1:0]     i_tol,
    input  logic [tce_pkg::VAL_W-1:0]     i_missing,
    output logic                          o_valid,
    output tce_pkg::t_cmp_item            o_item
);
    import tce_pkg::*;

    // stage a: missing detection, difference and magnitudes
    logic                    r_a_valid;
    logic signed [VAL_W-1:0] r_a_va, r_a_vb;
    logic                    r_a_start, r_a_miss_a, r_a_miss_b, r_a_eq, r_a_zero;
    logic                    r_a_abs_pass;
    logic [ERR_W-1:0]        r_a_err;
    logic [VAL_W-1:0]        r_a_mag_a;

    logic [VAL_W:0]          n_diff;
    logic [VAL_W:0]          n_diff_abs;
    logic [VAL_W:0]          n_mag_a;
    logic [ERR_W-1:0]        n_err;

    always_comb begin
        n_diff     = {i_value_a[VAL_W-1], i_value_a} - {i_value_b[VAL_W-1], i_value_b};
        n_diff_abs = n_diff[VAL_W] ? (~n_diff + 1'b1) : n_diff;
        n_err      = n_diff_abs[ERR_W-1:0];
        n_mag_a    = i_value_a[VAL_W-1] ? (~{1'b1, i_value_a} + 1'b1) : {1'b0, i_value_a};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (i_en) begin
            r_a_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_va       <= i_value_a;
            r_a_vb       <= i_value_b;
            r_a_start    <= i_start;
            r_a_miss_a   <= (i_value_a == i_missing);
            r_a_miss_b   <= (i_value_b == i_missing);
            r_a_eq       <= (i_value_a == i_value_b);
            r_a_zero     <= (i_value_a == '0);
            r_a_err      <= n_err;
            r_a_abs_pass <= (n_err < i_tol);
            r_a_mag_a    <= n_mag_a[VAL_W-1:0];
        end
    end

    // stage b: squared error and relative threshold products
    logic                    r_b_valid;
    logic signed [VAL_W-1:0] r_b_va, r_b_vb;
    logic                    r_b_start, r_b_miss_a, r_b_miss_b, r_b_eq, r_b_zero;
    logic                    r_b_abs_pass;
    logic [ERR_W-1:0]        r_b_err;
    logic [PROD_W-1:0]       r_b_sq;
    logic [PROD_W-1:0]       r_b_rel_lim;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (i_en) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_b_va       <= r_a_va;
            r_b_vb       <= r_a_vb;
            r_b_start    <= r_a_start;
            r_b_miss_a   <= r_a_miss_a;
            r_b_miss_b   <= r_a_miss_b;
            r_b_eq       <= r_a_eq;
            r_b_zero     <= r_a_zero;
            r_b_abs_pass <= r_a_abs_pass;
            r_b_err      <= r_a_err;
            r_b_sq       <= PROD_W'(r_a_err) * PROD_W'(r_a_err);
            r_b_rel_lim  <= PROD_W'(i_tol) * PROD_W'(r_a_mag_a);
        end
    end

    // stage c: tolerance decision and mismatch flag
    logic n_agree;
    logic n_rel_pass;
    logic n_mismatch;

    always_comb begin
        if (r_b_zero) begin
            n_rel_pass = (i_tol > Q_ONE);
        end else begin
            n_rel_pass = (PROD_W'({r_b_err, {FRAC_W{1'b0}}}) < r_b_rel_lim);
        end
        case (i_mode)
            CMP_ABS: n_agree = r_b_eq || r_b_abs_pass;
            CMP_REL: n_agree = r_b_eq || n_rel_pass;
            default: n_agree = r_b_eq;
        endcase
        if (r_b_miss_a && r_b_miss_b) begin
            n_mismatch = 1'b0;
        end else if (r_b_miss_a != r_b_miss_b) begin
            n_mismatch = 1'b1;
        end else begin
            n_mismatch = !n_agree;
        end
    end

    t_cmp_item r_c_item;
    logic      r_c_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (i_en) begin
            r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_c_item.mismatch <= n_mismatch;
            r_c_item.miss_a   <= r_b_miss_a;
            r_c_item.miss_b   <= r_b_miss_b;
            r_c_item.start    <= r_b_start;
            r_c_item.value_a  <= r_b_va;
            r_c_item.value_b  <= r_b_vb;
            r_c_item.abs_err  <= r_b_err;
            r_c_item.sq_term  <= r_b_sq[PROD_W-1:FRAC_W];
        end
    end

    assign o_valid = r_c_valid;
    assign o_item  = r_c_item;

endmodule

// File: rtl/core/tolerance_compare_error_stats.sv
// Point-by-point compare of two Q16.16 sample streams with running error
// statistics.
// Input channel s_axis: tdata carries value_a and value_b, tuser the
// start_record flag that clears all statistics before the item is counted.
// Output channel m_axis: one result item per input item, carrying the
// mismatch flag of that point and every statistic after it, in order.
// Configuration: i_cfg_we writes i_cfg_wdata into register i_cfg_index
// (0 compare mode, 1 tolerance, 2 missing code); write only while idle.
// Pipeline: the input register feeds difference, multipliers, tolerance decision
// and statistics update, each in its own registered stage.
// Throughput: one item per cycle unless m_axis stalls; 32x32 multipliers
// are pipelined; the accumulators loop back through the result register.
// When the receiver stalls, the whole pipeline holds and the result stays
// on m_axis; a skid register takes one more item, then s_axis_tready drops
// for as long as the stall lasts.
// Reset clears the statistics, configuration registers and all valids.
module tolerance_compare_error_stats (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // configuration
    input  logic                               i_cfg_we,
    input  logic [tce_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [tce_pkg::VAL_W-1:0]          i_cfg_wdata,
    // input stream
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // [31:0] value_a, [63:32] value_b
    input  logic [tce_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // [0] start_record
    input  logic                               s_axis_tuser,
    // result stream
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [0] mismatch, [32:1] diff_total, [64:33] grid_total,
    // [96:65] present_a_total, [128:97] present_b_total,
    // [160:129] both_present_total, [224:161] sum_of_a, [288:225] sum_of_b,
    // [351:289] squared_error_sum, [384:352] peak_abs_error, rest zero
    output logic [tce_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);
    import tce_pkg::*;

    // configuration registers
    logic [1:0]       r_mode;
    logic [VAL_W-1:0] r_tol;
    logic [VAL_W-1:0] r_missing;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= CMP_EXACT;
            r_tol     <= '0;
            r_missing <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_MODE:    r_mode    <= i_cfg_wdata[1:0];
                REG_TOL:     r_tol     <= i_cfg_wdata;
                REG_MISSING: r_missing <= i_cfg_wdata;
                default:     ;
            endcase
        end
    end

    // pipeline advance and skid register on the input side
    logic                  r_out_valid;
    logic                  w_en;
    logic                  w_in_acc;
    logic                  r_skid_valid;
    logic [IN_TDATA_W-1:0] r_skid_data;
    logic                  r_skid_start;

    assign w_en          = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_skid_valid;
    assign w_in_acc      = s_axis_tvalid && !r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_valid <= 1'b0;
        end else if (w_en) begin
            r_skid_valid <= 1'b0;
        end else if (w_in_acc) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!w_en && w_in_acc) begin
            r_skid_data  <= s_axis_tdata;
            r_skid_start <= s_axis_tuser;
        end
    end

    // input register
    logic                  r_in_valid;
    logic [IN_TDATA_W-1:0] r_in_data;
    logic                  r_in_start;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_en) begin
            r_in_valid <= r_skid_valid || w_in_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (r_skid_valid) begin
                r_in_data  <= r_skid_data;
                r_in_start <= r_skid_start;
            end else begin
                r_in_data  <= s_axis_tdata;
                r_in_start <= s_axis_tuser;
            end
        end
    end

    // compare pipeline
    logic      w_cmp_valid;
    t_cmp_item w_cmp;

    tce_compare u_compare (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_en),
        .i_valid   (r_in_valid),
        .i_value_a (r_in_data[VAL_W-1:0]),
        .i_value_b (r_in_data[2*VAL_W-1:VAL_W]),
        .i_start   (r_in_start),
        .i_mode    (r_mode),
        .i_tol     (r_tol),
        .i_missing (r_missing),
        .o_valid   (w_cmp_valid),
        .o_item    (w_cmp)
    );

    // statistics registers, which are also the result register
    logic                    r_mismatch;
    logic [CNT_W-1:0]        r_diff_cnt, r_grid_cnt, r_pa_cnt, r_pb_cnt, r_both_cnt;
    logic signed [SUM_W-1:0] r_sum_a, r_sum_b;
    logic [SQ_W-1:0]         r_sq_sum;
    logic [PEAK_W-1:0]       r_peak;

    logic [CNT_W-1:0]        n_diff_cnt, n_grid_cnt, n_pa_cnt, n_pb_cnt, n_both_cnt;
    logic signed [SUM_W-1:0] n_sum_a, n_sum_b;
    logic [SQ_W-1:0]         n_sq_sum;
    logic [PEAK_W-1:0]       n_peak;

    logic [CNT_W-1:0]        w_b_diff, w_b_grid, w_b_pa, w_b_pb, w_b_both;
    logic signed [SUM_W-1:0] w_b_sum_a, w_b_sum_b;
    logic [SQ_W-1:0]         w_b_sq;
    logic [PEAK_W-1:0]       w_b_peak;
    logic [SUM_W:0]          w_add_a, w_add_b;
    logic [SQ_W:0]           w_add_sq;
    logic                    w_both;

    // saturating count by one
    function automatic logic [CNT_W-1:0] cnt_inc(input logic [CNT_W-1:0] c);
        return (c == '1) ? c : c + 1'b1;
    endfunction

    always_comb begin
        // start of record clears before counting
        w_b_diff  = w_cmp.start ? '0 : r_diff_cnt;
        w_b_grid  = w_cmp.start ? '0 : r_grid_cnt;
        w_b_pa    = w_cmp.start ? '0 : r_pa_cnt;
        w_b_pb    = w_cmp.start ? '0 : r_pb_cnt;
        w_b_both  = w_cmp.start ? '0 : r_both_cnt;
        w_b_sum_a = w_cmp.start ? '0 : r_sum_a;
        w_b_sum_b = w_cmp.start ? '0 : r_sum_b;
        w_b_sq    = w_cmp.start ? '0 : r_sq_sum;
        w_b_peak  = w_cmp.start ? '0 : r_peak;
        w_both    = !w_cmp.miss_a && !w_cmp.miss_b;

        w_add_a  = {w_b_sum_a[SUM_W-1], w_b_sum_a}
                 + {{(SUM_W-VAL_W+1){w_cmp.value_a[VAL_W-1]}}, w_cmp.value_a};
        w_add_b  = {w_b_sum_b[SUM_W-1], w_b_sum_b}
                 + {{(SUM_W-VAL_W+1){w_cmp.value_b[VAL_W-1]}}, w_cmp.value_b};
        w_add_sq = {1'b0, w_b_sq} + (SQ_W+1)'(w_cmp.sq_term);

        n_grid_cnt = cnt_inc(w_b_grid);
        n_diff_cnt = w_cmp.mismatch ? cnt_inc(w_b_diff) : w_b_diff;
        n_pa_cnt   = w_cmp.miss_a ? w_b_pa : cnt_inc(w_b_pa);
        n_pb_cnt   = w_cmp.miss_b ? w_b_pb : cnt_inc(w_b_pb);
        n_both_cnt = w_both ? cnt_inc(w_b_both) : w_b_both;

        // signed sums clamp on overflow
        n_sum_a = w_b_sum_a;
        if (!w_cmp.miss_a) begin
            if (w_add_a[SUM_W] != w_add_a[SUM_W-1]) begin
                n_sum_a = w_add_a[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                         : {1'b0, {(SUM_W-1){1'b1}}};
            end else begin
                n_sum_a = w_add_a[SUM_W-1:0];
            end
        end
        n_sum_b = w_b_sum_b;
        if (!w_cmp.miss_b) begin
            if (w_add_b[SUM_W] != w_add_b[SUM_W-1]) begin
                n_sum_b = w_add_b[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                         : {1'b0, {(SUM_W-1){1'b1}}};
            end else begin
                n_sum_b = w_add_b[SUM_W-1:0];
            end
        end

        // squared error and peak only where both samples are present
        n_sq_sum = w_b_sq;
        n_peak   = w_b_peak;
        if (w_both) begin
            n_sq_sum = w_add_sq[SQ_W] ? '1 : w_add_sq[SQ_W-1:0];
            if (PEAK_W'(w_cmp.abs_err) > w_b_peak) begin
                n_peak = PEAK_W'(w_cmp.abs_err);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_mismatch  <= 1'b0;
            r_diff_cnt  <= '0;
            r_grid_cnt  <= '0;
            r_pa_cnt    <= '0;
            r_pb_cnt    <= '0;
            r_both_cnt  <= '0;
            r_sum_a     <= '0;
            r_sum_b     <= '0;
            r_sq_sum    <= '0;
            r_peak      <= '0;
        end else if (w_en) begin
            r_out_valid <= w_cmp_valid;
            if (w_cmp_valid) begin
                r_mismatch <= w_cmp.mismatch;
                r_diff_cnt <= n_diff_cnt;
                r_grid_cnt <= n_grid_cnt;
                r_pa_cnt   <= n_pa_cnt;
                r_pb_cnt   <= n_pb_cnt;
                r_both_cnt <= n_both_cnt;
                r_sum_a    <= n_sum_a;
                r_sum_b    <= n_sum_b;
                r_sq_sum   <= n_sq_sum;
                r_peak     <= n_peak;
            end
        end
    end

    // result packing
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_TDATA_W'({r_peak, r_sq_sum, r_sum_b, r_sum_a, r_both_cnt,
                                         r_pb_cnt, r_pa_cnt, r_grid_cnt, r_diff_cnt,
                                         r_mismatch});

endmodule

// File: tb/sv/tolerance_compare_error_stats_tb.sv
`timescale 1ns / 1ps

module tolerance_compare_error_stats_tb;

    import tce_pkg::*;

    // codes the package leaves unnamed
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam logic [1:0]           CMP_SPARE  = 2'd3;

    localparam logic [SQ_W-1:0] SQ_TOP       = '1;
    localparam int unsigned     HOLD_CYCLES  = 80;
    localparam int unsigned     PHASE_POINTS = 235;
    localparam int unsigned     PHASES       = 8;
    localparam int unsigned     TAIL_CYCLES  = 20;

    // statistics as laid out on m_axis_tdata, mismatch in bit 0
    typedef struct packed {
        logic [PEAK_W-1:0] peak_abs_error;
        logic [SQ_W-1:0]   squared_error_sum;
        logic [SUM_W-1:0]  sum_of_b;
        logic [SUM_W-1:0]  sum_of_a;
        logic [CNT_W-1:0]  both_present_total;
        logic [CNT_W-1:0]  present_b_total;
        logic [CNT_W-1:0]  present_a_total;
        logic [CNT_W-1:0]  grid_total;
        logic [CNT_W-1:0]  diff_total;
        logic              mismatch;
    } t_stats;

    // directed rows: a new compare setting or one grid point
    typedef enum logic {ROW_SETTING, ROW_POINT} t_row_kind;

    typedef struct packed {
        t_row_kind         kind;
        logic [1:0]        mode;
        logic [VAL_W-1:0]  tol;
        logic [VAL_W-1:0]  miss;
        logic [VAL_W-1:0]  sample_a;
        logic [VAL_W-1:0]  sample_b;
        logic              restart;
        logic              typed;
        logic              exp_mis;
        logic [CNT_W-1:0]  exp_diff;
        logic [CNT_W-1:0]  exp_grid;
    } t_dir_row;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_index   = '0;
    logic [VAL_W-1:0]       i_cfg_wdata   = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    // [31:0] value_a, [63:32] value_b
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    // [0] start_record
    logic                   s_axis_tuser  = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // [0] mismatch, [32:1] diff_total, [64:33] grid_total, [96:65] present_a_total,
    // [128:97] present_b_total, [160:129] both_present_total, [224:161] sum_of_a,
    // [288:225] sum_of_b, [351:289] squared_error_sum, [384:352] peak_abs_error
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    // predictor copy of registers and statistics
    logic [1:0]       cfg_mode    = '0;
    logic [VAL_W-1:0] cfg_tol     = '0;
    logic [VAL_W-1:0] cfg_missing = '0;
    t_stats           running     = '0;

    t_stats   stats_due[$];
    t_dir_row dir_tab[$];

    int unsigned errors        = 0;
    int unsigned points_sent   = 0;
    int unsigned restarts      = 0;
    int unsigned flagged       = 0;
    int unsigned settings_used = 0;
    int unsigned tx_idle_pct   = 0;
    int unsigned rx_stall_pct  = 0;
    int unsigned hold_req      = 0;
    int unsigned hold_seen     = 0;
    int unsigned hold_left     = 0;
    int unsigned phase;
    logic [VAL_W-1:0] mode_word, tol_word, miss_word;

    tolerance_compare_error_stats i_dut (.*);

    always #2 i_clk = ~i_clk;

    // saturating point counter
    function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] c);
        return (&c) ? c : c + 1'b1;
    endfunction

    // signed 64-bit sum clamped at both ends
    function automatic logic [SUM_W-1:0] add_clamped(input logic [SUM_W-1:0] acc,
                                                     input logic [VAL_W-1:0] v);
        logic [SUM_W:0] s;
        s = {acc[SUM_W-1], acc} + {{(SUM_W-VAL_W+1){v[VAL_W-1]}}, v};
        if (s[SUM_W] != s[SUM_W-1])
            return s[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
        return s[SUM_W-1:0];
    endfunction

    // pass test of two present samples under the current mode
    function automatic bit within_tolerance(input logic [VAL_W-1:0] ra,
                                            input logic [VAL_W-1:0] rb,
                                            input logic [32:0] err);
        logic [VAL_W-1:0] mag_a;
        logic [63:0]      lhs, rhs;
        if (ra == rb)
            return 1'b1;
        mag_a = ra[VAL_W-1] ? (~ra + 1'b1) : ra;
        lhs   = {15'b0, err, 16'b0};
        rhs   = {32'b0, cfg_tol} * {32'b0, mag_a};
        case (cfg_mode)
            CMP_ABS: return err < {1'b0, cfg_tol};
            CMP_REL: return (ra == '0) ? (cfg_tol > Q_ONE) : (lhs < rhs);
            default: return 1'b0;
        endcase
    endfunction

    // fold one grid point into the running statistics
    function automatic t_stats fold_point(input logic [VAL_W-1:0] ra,
                                          input logic [VAL_W-1:0] rb,
                                          input bit restart);
        logic        miss_a, miss_b;
        logic [32:0] delta, err;
        logic [63:0] sq, sq_acc;
        miss_a = (ra == cfg_missing);
        miss_b = (rb == cfg_missing);
        if (restart)
            running = '0;
        running.mismatch   = 1'b0;
        running.grid_total = bump(running.grid_total);
        if (!(miss_a && miss_b)) begin
            delta = {ra[VAL_W-1], ra} - {rb[VAL_W-1], rb};
            err   = delta[32] ? (~delta + 1'b1) : delta;
            running.mismatch = (miss_a != miss_b) || !within_tolerance(ra, rb, err);
            if (running.mismatch)
                running.diff_total = bump(running.diff_total);
            if (!miss_a) begin
                running.present_a_total = bump(running.present_a_total);
                running.sum_of_a        = add_clamped(running.sum_of_a, ra);
            end
            if (!miss_b) begin
                running.present_b_total = bump(running.present_b_total);
                running.sum_of_b        = add_clamped(running.sum_of_b, rb);
            end
            if (!miss_a && !miss_b) begin
                sq     = ({31'b0, err} * {31'b0, err}) >> FRAC_W;
                sq_acc = {1'b0, running.squared_error_sum} + sq;
                running.squared_error_sum  = sq_acc[63] ? SQ_TOP : sq_acc[SQ_W-1:0];
                running.both_present_total = bump(running.both_present_total);
                if (err > running.peak_abs_error)
                    running.peak_abs_error = err;
            end
        end
        return running;
    endfunction

    function automatic t_dir_row setting_row(input logic [1:0] mode,
                                             input logic [VAL_W-1:0] tol,
                                             input logic [VAL_W-1:0] miss);
        t_dir_row r;
        r      = '0;
        r.kind = ROW_SETTING;
        r.mode = mode;
        r.tol  = tol;
        r.miss = miss;
        return r;
    endfunction

    function automatic t_dir_row open_row(input logic [VAL_W-1:0] a,
                                          input logic [VAL_W-1:0] b, input bit restart);
        t_dir_row r;
        r          = '0;
        r.kind     = ROW_POINT;
        r.sample_a = a;
        r.sample_b = b;
        r.restart  = restart;
        return r;
    endfunction

    // point whose mismatch flag and two counts are plain to see
    function automatic t_dir_row known_row(input logic [VAL_W-1:0] a,
                                           input logic [VAL_W-1:0] b, input bit restart,
                                           input bit mis, input int unsigned diff,
                                           input int unsigned grid);
        t_dir_row r;
        r          = open_row(a, b, restart);
        r.typed    = 1'b1;
        r.exp_mis  = mis;
        r.exp_diff = diff;
        r.exp_grid = grid;
        return r;
    endfunction

    // sample with extremes, the missing code and small values mixed in
    function automatic logic [VAL_W-1:0] draw_sample();
        case ($urandom_range(9))
            0: begin
                case ($urandom_range(4))
                    0:       return 32'h8000_0000;
                    1:       return 32'h7FFF_FFFF;
                    2:       return 32'h0000_0000;
                    3:       return 32'h0000_0001;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
            1:       return cfg_missing;
            2, 3:    return $signed($urandom) >>> $urandom_range(31, 1);
            default: return $urandom;
        endcase
    endfunction

    task automatic check_field(input string tag, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %h got %h", $time, tag, want, got);
            errors++;
        end
    endtask

    // compare one result item with the oldest expectation
    task automatic check_result(input logic [OUT_TDATA_W-1:0] word);
        t_stats got, want;
        got = word[$bits(t_stats)-1:0];
        if (stats_due.size() == 0) begin
            $display("%0t: result item with nothing expected, got %h", $time, got);
            errors++;
            return;
        end
        want = stats_due.pop_front();
        if (got.mismatch)
            flagged++;
        check_field("mismatch", 64'(want.mismatch), 64'(got.mismatch));
        check_field("diff_total", 64'(want.diff_total), 64'(got.diff_total));
        check_field("grid_total", 64'(want.grid_total), 64'(got.grid_total));
        check_field("present_a_total", 64'(want.present_a_total),
                    64'(got.present_a_total));
        check_field("present_b_total", 64'(want.present_b_total),
                    64'(got.present_b_total));
        check_field("both_present_total", 64'(want.both_present_total),
                    64'(got.both_present_total));
        check_field("sum_of_a", want.sum_of_a, got.sum_of_a);
        check_field("sum_of_b", want.sum_of_b, got.sum_of_b);
        check_field("squared_error_sum", 64'(want.squared_error_sum),
                    64'(got.squared_error_sum));
        check_field("peak_abs_error", 64'(want.peak_abs_error), 64'(got.peak_abs_error));
        check_field("padding", '0, 64'(word[OUT_TDATA_W-1:$bits(t_stats)]));
    endtask

    // offer one grid point and queue its predicted statistics once taken
    task automatic offer_point(input logic [VAL_W-1:0] ra, input logic [VAL_W-1:0] rb,
                               input bit restart, input bit typed, input bit t_mis,
                               input logic [CNT_W-1:0] t_diff,
                               input logic [CNT_W-1:0] t_grid);
        t_stats pred;
        if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            do begin
                @(posedge i_clk);
            end while ($urandom_range(99) < tx_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {rb, ra};
        s_axis_tuser  <= restart;
        do begin
            @(posedge i_clk);
        end while (!s_axis_tready);
        pred = fold_point(ra, rb, restart);
        if (typed) begin
            pred.mismatch   = t_mis;
            pred.diff_total = t_diff;
            pred.grid_total = t_grid;
        end
        stats_due.push_back(pred);
        points_sent++;
        if (restart)
            restarts++;
    endtask

    // program all registers once the pipeline has emptied
    task automatic apply_setting(input logic [VAL_W-1:0] mode_val,
                                 input logic [VAL_W-1:0] tol, input logic [VAL_W-1:0] miss,
                                 input bit poke_unused);
        s_axis_tvalid <= 1'b0;
        while (stats_due.size() != 0)
            @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= REG_MODE;
        i_cfg_wdata <= mode_val;
        @(posedge i_clk);
        i_cfg_index <= REG_TOL;
        i_cfg_wdata <= tol;
        @(posedge i_clk);
        i_cfg_index <= REG_MISSING;
        i_cfg_wdata <= miss;
        @(posedge i_clk);
        // a write to the spare index must leave everything alone
        if (poke_unused) begin
            i_cfg_index <= REG_UNUSED;
            i_cfg_wdata <= $urandom;
            @(posedge i_clk);
        end
        i_cfg_we    <= 1'b0;
        cfg_mode    = mode_val[1:0];
        cfg_tol     = tol;
        cfg_missing = miss;
        settings_used++;
    endtask

    // random points, three in ten near the pass/fail boundaries of the current tolerance
    task automatic run_random(input int unsigned count, input int unsigned hold_at,
                              input int unsigned drain_at);
        logic [VAL_W-1:0] ra, rb, mag, step;
        logic [63:0]      rel_full;
        for (int unsigned i = 0; i < count; i++) begin
            if (i == hold_at)
                hold_req <= hold_req + 1;
            if (i == drain_at) begin
                s_axis_tvalid <= 1'b0;
                while (stats_due.size() != 0)
                    @(posedge i_clk);
            end
            ra = draw_sample();
            case ($urandom_range(19))
                0, 1: rb = cfg_missing;
                2, 3: rb = ra;
                4, 5, 6: begin
                    step = cfg_tol + $urandom_range(2) - 1;
                    rb   = $urandom_range(1) ? ra + step : ra - step;
                end
                7, 8, 9: rb = ra + ($signed($urandom) >>> $urandom_range(31, 4));
                10, 11, 12: begin
                    mag      = ra[VAL_W-1] ? (~ra + 1'b1) : ra;
                    rel_full = ({32'b0, cfg_tol} * {32'b0, mag}) >> FRAC_W;
                    step     = rel_full[VAL_W-1:0] + $urandom_range(2) - 1;
                    rb       = $urandom_range(1) ? ra + step : ra - step;
                end
                default: rb = draw_sample();
            endcase
            offer_point(ra, rb, $urandom_range(63) == 0, 1'b0, 1'b0, '0, '0);
        end
    endtask

    // result side: random stalls, long hold-off on request, checking
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready)
                check_result(m_axis_tdata);
            if (hold_req != hold_seen) begin
                hold_seen = hold_req;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    // directed table, then random phases under changing settings and idling
    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset setting: exact compare, zero is the missing code
        dir_tab.push_back(known_row(32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, 0, 1));
        dir_tab.push_back(known_row(32'h0000_0000, 32'h0000_0005, 1'b0, 1'b1, 1, 2));
        dir_tab.push_back(known_row(32'h0000_0007, 32'h0000_0007, 1'b0, 1'b0, 1, 3));
        dir_tab.push_back(known_row(32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 1'b1, 2, 4));
        dir_tab.push_back(known_row(32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 1'b1, 3, 5));
        // absolute tolerance of 1.0, most negative value is missing
        dir_tab.push_back(setting_row(CMP_ABS, Q_ONE, 32'h8000_0000));
        dir_tab.push_back(known_row(32'h0000_0000, 32'h0000_FFFF, 1'b1, 1'b0, 0, 1));
        dir_tab.push_back(known_row(32'h0000_0000, 32'h0001_0000, 1'b0, 1'b1, 1, 2));
        dir_tab.push_back(known_row(32'h8000_0000, 32'h8000_0000, 1'b0, 1'b0, 1, 3));
        dir_tab.push_back(known_row(32'h8000_0000, 32'h0000_0001, 1'b0, 1'b1, 2, 4));
        dir_tab.push_back(known_row(32'hFFFF_FFFF, 32'h0000_0001, 1'b0, 1'b0, 2, 5));
        dir_tab.push_back(known_row(32'h7FFF_FFFF, 32'h8000_0001, 1'b0, 1'b1, 3, 6));
        // zero tolerance lets only equal samples through
        dir_tab.push_back(setting_row(CMP_ABS, 32'h0000_0000, 32'h8000_0000));
        dir_tab.push_back(known_row(32'h0000_0001, 32'h0000_0002, 1'b0, 1'b1, 4, 7));
        dir_tab.push_back(known_row(32'h0000_0003, 32'h0000_0003, 1'b0, 1'b0, 4, 8));
        // relative mode, zero a against a tolerance of exactly 1.0
        dir_tab.push_back(setting_row(CMP_REL, Q_ONE, 32'h7FFF_FFFF));
        dir_tab.push_back(known_row(32'h0000_0000, 32'h0000_0001, 1'b1, 1'b1, 1, 1));
        dir_tab.push_back(known_row(32'h0002_0000, 32'h0003_0000, 1'b0, 1'b0, 1, 2));
        dir_tab.push_back(open_row(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0));
        // tolerance just over 1.0 lets a zero a pass
        dir_tab.push_back(setting_row(CMP_REL, 32'h0001_0001, 32'h7FFF_FFFF));
        dir_tab.push_back(known_row(32'h0000_0000, 32'h0000_0001, 1'b0, 1'b0, 1, 4));
        dir_tab.push_back(open_row(32'h8000_0000, 32'h7FFF_FFFE, 1'b0));
        dir_tab.push_back(open_row(32'hFFFF_0000, 32'hFFFE_8000, 1'b0));
        // widest tolerance with the widest difference
        dir_tab.push_back(setting_row(CMP_REL, 32'hFFFF_FFFF, 32'h7FFF_FFFF));
        dir_tab.push_back(open_row(32'h8000_0000, 32'h7FFF_FFFE, 1'b0));
        // spare mode code falls back to exact compare
        dir_tab.push_back(setting_row(CMP_SPARE, 32'h0000_0000, 32'h7FFF_FFFF));
        dir_tab.push_back(known_row(32'h0000_0001, 32'h0000_0002, 1'b1, 1'b1, 1, 1));
        dir_tab.push_back(known_row(32'h0000_0005, 32'h0000_0005, 1'b0, 1'b0, 1, 2));
        dir_tab.push_back(open_row(32'h0000_0000, 32'h0000_0000, 1'b0));

        foreach (dir_tab[i]) begin
            if (dir_tab[i].kind == ROW_SETTING)
                apply_setting({30'b0, dir_tab[i].mode}, dir_tab[i].tol, dir_tab[i].miss,
                              dir_tab[i].mode == CMP_SPARE);
            else
                offer_point(dir_tab[i].sample_a, dir_tab[i].sample_b, dir_tab[i].restart,
                            dir_tab[i].typed, dir_tab[i].exp_mis, dir_tab[i].exp_diff,
                            dir_tab[i].exp_grid);
        end

        for (phase = 0; phase < PHASES; phase++) begin
            case (phase % 4)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 66; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 66; end
                default: begin tx_idle_pct = 32; rx_stall_pct = 32; end
            endcase
            mode_word = $urandom;
            case (phase)
                0:       mode_word[1:0] = CMP_ABS;
                1, 3, 6: mode_word[1:0] = CMP_REL;
                2:       mode_word[1:0] = CMP_EXACT;
                5:       mode_word[1:0] = CMP_SPARE;
                default: mode_word[1:0] = CMP_ABS;
            endcase
            case (phase)
                0:       tol_word = 32'hFFFF_FFFF;
                1:       tol_word = Q_ONE;
                2:       tol_word = 32'h0000_0000;
                3:       tol_word = 32'h0001_0001;
                default: tol_word = $urandom >> $urandom_range(31, 0);
            endcase
            case (phase % 4)
                0:       miss_word = 32'h8000_0000;
                1:       miss_word = 32'h7FFF_FFFF;
                2:       miss_word = 32'h0000_0000;
                default: miss_word = $urandom;
            endcase
            apply_setting(mode_word, tol_word, miss_word, phase == 5);
            run_random(PHASE_POINTS, (phase == 4) ? 60 : PHASE_POINTS,
                       (phase == 6) ? 120 : PHASE_POINTS);
        end

        s_axis_tvalid <= 1'b0;
        while (stats_due.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("covered %0d grid points, %0d directed, under %0d compare settings",
                 points_sent, 29 - 6, settings_used);
        $display("%0d points flagged as differing, %0d record restarts", flagged, restarts);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // watchdog
    initial begin
        #2_000_000;
        $display("timed out with %0d result items outstanding", stats_due.size());
        $display("Simulation FAILED");
        $finish;
    end

endmodule

// File: tolerance_compare_error_stats.f
rtl/core/tce_pkg.sv
rtl/core/tce_compare.sv
rtl/core/tolerance_compare_error_stats.sv
tb/sv/tolerance_compare_error_stats_tb.sv
